// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers, clocked on i_clk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CSA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CSA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/csa_pkg.sv =====
`default_nettype none
package csa_pkg;

    localparam int ADDR_BITS = 16;
    localparam int ID_BITS   = 8;
    localparam int SIZE_W    = 17;
    localparam int MAX_RESULTS = 32;

    localparam logic [SIZE_W-1:0] TOT_MAX = SIZE_W'(1) << ADDR_BITS;

    // Commands
    localparam logic [1:0] CMD_REQ = 2'd0;
    localparam logic [1:0] CMD_REL = 2'd1;
    localparam logic [1:0] CMD_CMP = 2'd2;
    localparam logic [1:0] CMD_REP = 2'd3;

    // Fit strategies
    localparam logic [1:0] STRAT_FIRST = 2'd0;
    localparam logic [1:0] STRAT_BEST  = 2'd1;
    localparam logic [1:0] STRAT_WORST = 2'd2;
    localparam logic [1:0] STRAT_BAD   = 2'd3;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOFIT    = 3'd1;
    localparam logic [2:0] ST_UNKNOWN  = 3'd2;
    localparam logic [2:0] ST_BADSTRAT = 3'd3;
    localparam logic [2:0] ST_NOFREE   = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [ID_BITS-1:0] proc_id;
        logic [SIZE_W-1:0] req_size;
        logic [1:0]        strategy;
    } t_cmd_item;

    typedef struct packed {
        logic [2:0]           status;
        logic [ADDR_BITS-1:0] seg_start;
        logic [ADDR_BITS-1:0] seg_end;
        logic                 seg_in_use;
        logic [ID_BITS-1:0]   seg_owner;
        logic                 last;
    } t_res_item;

    // One table entry as held in the segment memory.
    typedef struct packed {
        logic [ADDR_BITS-1:0] seg_start;
        logic [ADDR_BITS-1:0] seg_end;
        logic                 used;
        logic [ID_BITS-1:0]   owner;
    } t_entry;

    // Error result: given status, all other fields zero, final item.
    function automatic t_res_item err_res(input logic [2:0] st);
        t_res_item r;
        r        = '0;
        r.status = st;
        r.last   = 1'b1;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/csa_ram.sv =====
`default_nettype none
module csa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/contiguous_segment_allocator.sv =====
// Contiguous segment allocator. The segment table (start, end, owner, used) sits in one
// single-port-read / single-port-write RAM of MAX_SEGMENTS entries with a registered read
// port; a sequencer walks it one entry per cycle. A request scans the table and, when a
// hole is split, moves the entries above it up one slot; a release scans, then moves the
// merged entries down; a compact scans and repacks the used segments; a report reads the
// reported segments one at a time. Output stalls hold the sequencer. Writing total_size
// rebuilds the table as one free segment.
// The input is taken only while the sequencer is idle; results leave through an output
// register, so a new item can be taken while the last result still waits.
`default_nettype none
module contiguous_segment_allocator import csa_pkg::*; #(
    parameter int MAX_SEGMENTS = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_cmd_item         i_in,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_res_item              o_out,
    input  wire logic              i_cfg_we,
    input  wire logic [SIZE_W-1:0] i_cfg_data
);

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int EW = $bits(t_entry);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SEGMENTS);

    localparam logic [3:0] S_INIT    = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_SCAN    = 4'd2;
    localparam logic [3:0] S_RQ_DEC  = 4'd3;
    localparam logic [3:0] S_SHIFT   = 4'd4;
    localparam logic [3:0] S_RQ_W1   = 4'd5;
    localparam logic [3:0] S_RQ_W0   = 4'd6;
    localparam logic [3:0] S_RL_RDN  = 4'd7;
    localparam logic [3:0] S_RL_GOTN = 4'd8;
    localparam logic [3:0] S_CP_END  = 4'd9;
    localparam logic [3:0] S_RP_RD   = 4'd10;
    localparam logic [3:0] S_RP_LD   = 4'd11;
    localparam logic [3:0] S_EMIT    = 4'd12;

    // Control state
    logic [3:0]        r_state, n_state;
    logic [3:0]        r_after, n_after;
    logic [SIZE_W-1:0] r_tot, n_tot;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_dv, n_dv;
    logic              r_stop, n_stop;
    logic              r_found, n_found;
    logic              r_sdv, n_sdv;
    logic              r_up, n_up;
    logic              r_anyfree, n_anyfree;
    logic              r_ov, n_ov;
    logic [CW-1:0]     r_ri, n_ri;
    logic [CW-1:0]     r_src, n_src;
    logic [CW-1:0]     r_wa, n_wa;
    logic [CW-1:0]     r_left, n_left;
    logic [CW-1:0]     r_nw, n_nw;

    // Payload
    t_cmd_item         r_item, n_item;
    logic [IW-1:0]     r_di, n_di;
    logic [IW-1:0]     r_pi, n_pi;
    t_entry            r_pe, n_pe;
    t_entry            r_prev, n_prev;
    logic [SIZE_W-1:0] r_psz, n_psz;
    logic [SIZE_W-1:0] r_next, n_next;
    t_res_item         r_res, n_res;
    t_res_item         r_out, n_out;

    // RAM port
    logic          ram_we;
    logic [IW-1:0] ram_wa;
    logic [EW-1:0] ram_wd;
    logic [IW-1:0] ram_ra;
    logic [EW-1:0] ram_rd;
    t_entry        rd;
    t_entry        we_ent;

    logic [SIZE_W-1:0] d_size;
    logic [SIZE_W-1:0] cp_end;
    logic [SIZE_W-1:0] tot_m1;
    logic [SIZE_W-1:0] rq_nstart;
    logic [SIZE_W-1:0] rq_end;
    logic [CW-1:0]     pi_nx;
    logic [CW-1:0]     rl_p;
    logic [CW-1:0]     rl_d;
    logic              nfree, pfree, rep_last, fit;

    csa_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_wa),
        .i_wdata (ram_wd),
        .i_raddr (ram_ra),
        .o_rdata (ram_rd)
    );

    assign rd     = t_entry'(ram_rd);
    assign ram_wd = EW'(we_ent);

    // Datapath helpers
    assign d_size    = SIZE_W'(rd.seg_end) - SIZE_W'(rd.seg_start) + SIZE_W'(1);
    assign cp_end    = r_next + d_size - SIZE_W'(1);
    assign tot_m1    = r_tot - SIZE_W'(1);
    assign rq_nstart = SIZE_W'(r_pe.seg_start) + r_item.req_size;
    assign rq_end    = rq_nstart - SIZE_W'(1);
    assign pi_nx     = CW'(r_pi) + CW'(1);
    assign nfree     = (pi_nx < r_cnt) && !rd.used;
    assign pfree     = (r_pi != '0) && !r_prev.used;
    assign rl_p      = pfree ? CW'(r_pi) : pi_nx;
    assign rl_d      = CW'(nfree) + CW'(pfree);
    assign rep_last  = ((r_ri + CW'(1)) == r_cnt) || (32'(r_ri) == MAX_RESULTS - 1);
    assign fit       = !rd.used && (d_size >= r_item.req_size);

    always_comb begin
        n_state   = r_state;
        n_after   = r_after;
        n_tot     = r_tot;
        n_cnt     = r_cnt;
        n_dv      = r_dv;
        n_stop    = r_stop;
        n_found   = r_found;
        n_sdv     = r_sdv;
        n_up      = r_up;
        n_anyfree = r_anyfree;
        n_ov      = r_ov && !i_out_ready;
        n_ri      = r_ri;
        n_src     = r_src;
        n_wa      = r_wa;
        n_left    = r_left;
        n_nw      = r_nw;
        n_item    = r_item;
        n_di      = r_di;
        n_pi      = r_pi;
        n_pe      = r_pe;
        n_prev    = r_prev;
        n_psz     = r_psz;
        n_next    = r_next;
        n_res     = r_res;
        n_out     = r_out;
        ram_we    = 1'b0;
        ram_wa    = '0;
        ram_ra    = '0;
        we_ent    = '0;

        case (r_state)
            // One free segment covering the whole range
            S_INIT: begin
                ram_we         = 1'b1;
                we_ent.seg_end = tot_m1[ADDR_BITS-1:0];
                n_cnt          = CW'(1);
                n_state        = S_IDLE;
            end

            S_IDLE: begin
                if (i_in_valid) begin
                    n_item    = i_in;
                    n_ri      = '0;
                    n_dv      = 1'b0;
                    n_stop    = 1'b0;
                    n_found   = 1'b0;
                    n_nw      = '0;
                    n_next    = '0;
                    n_anyfree = 1'b0;
                    n_prev    = '0;
                    case (i_in.cmd)
                        CMD_REQ: begin
                            if (i_in.strategy == STRAT_BAD) begin
                                n_res   = err_res(ST_BADSTRAT);
                                n_state = S_EMIT;
                            end else if (i_in.req_size == '0) begin
                                n_res   = err_res(ST_NOFIT);
                                n_state = S_EMIT;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        CMD_REL, CMD_CMP: n_state = S_SCAN;
                        default: n_state = S_RP_RD;
                    endcase
                end
            end

            // Pipelined walk over the table: read one ahead, process last read
            S_SCAN: begin
                if ((r_ri < r_cnt) && !r_stop) begin
                    ram_ra = r_ri[IW-1:0];
                    n_ri   = r_ri + CW'(1);
                    n_dv   = 1'b1;
                    n_di   = r_ri[IW-1:0];
                end else begin
                    n_dv = 1'b0;
                end
                if (r_dv && !r_stop) begin
                    case (r_item.cmd)
                        CMD_REQ: begin
                            if (fit && (!r_found
                                    || (r_item.strategy == STRAT_BEST && d_size < r_psz)
                                    || (r_item.strategy == STRAT_WORST && d_size > r_psz)))
                            begin
                                n_found = 1'b1;
                                n_pi    = r_di;
                                n_pe    = rd;
                                n_psz   = d_size;
                                if (r_item.strategy == STRAT_FIRST) begin
                                    n_stop = 1'b1;
                                end
                            end
                        end
                        CMD_REL: begin
                            if (rd.used && rd.owner == r_item.proc_id) begin
                                n_found = 1'b1;
                                n_pi    = r_di;
                                n_pe    = rd;
                                n_stop  = 1'b1;
                            end else begin
                                n_prev = rd;
                            end
                        end
                        CMD_CMP: begin
                            // Repack used segments in place, lowest slot first
                            if (rd.used) begin
                                ram_we           = 1'b1;
                                ram_wa           = r_nw[IW-1:0];
                                we_ent.seg_start = r_next[ADDR_BITS-1:0];
                                we_ent.seg_end   = cp_end[ADDR_BITS-1:0];
                                we_ent.used      = 1'b1;
                                we_ent.owner     = rd.owner;
                                n_nw             = r_nw + CW'(1);
                                n_next           = r_next + d_size;
                            end else begin
                                n_anyfree = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                if (!r_dv && ((r_ri >= r_cnt) || r_stop)) begin
                    case (r_item.cmd)
                        CMD_REQ: n_state = S_RQ_DEC;
                        CMD_REL: begin
                            if (r_found) begin
                                n_state = S_RL_RDN;
                            end else begin
                                n_res   = err_res(ST_UNKNOWN);
                                n_state = S_EMIT;
                            end
                        end
                        default: n_state = S_CP_END;
                    endcase
                end
            end

            S_RQ_DEC: begin
                if (!r_found) begin
                    n_res   = err_res(ST_NOFIT);
                    n_state = S_EMIT;
                end else if (r_psz != r_item.req_size) begin
                    if (r_cnt >= CNT_MAX) begin
                        n_res   = err_res(ST_FULL);
                        n_state = S_EMIT;
                    end else begin
                        // Move entries above the hole up one slot
                        n_src   = r_cnt - CW'(1);
                        n_wa    = r_cnt;
                        n_left  = r_cnt - pi_nx;
                        n_up    = 1'b1;
                        n_sdv   = 1'b0;
                        n_after = S_RQ_W1;
                        n_state = S_SHIFT;
                    end
                end else begin
                    n_state = S_RQ_W0;
                end
            end

            // Block move, one entry per cycle
            S_SHIFT: begin
                if (r_left != '0) begin
                    ram_ra = r_src[IW-1:0];
                    n_src  = r_up ? r_src - CW'(1) : r_src + CW'(1);
                    n_left = r_left - CW'(1);
                    n_sdv  = 1'b1;
                end else begin
                    n_sdv = 1'b0;
                end
                if (r_sdv) begin
                    ram_we = 1'b1;
                    ram_wa = r_wa[IW-1:0];
                    we_ent = rd;
                    n_wa   = r_up ? r_wa - CW'(1) : r_wa + CW'(1);
                end
                if ((r_left == '0) && !r_sdv) begin
                    n_state = r_after;
                end
            end

            // Remainder of the split hole
            S_RQ_W1: begin
                ram_we           = 1'b1;
                ram_wa           = pi_nx[IW-1:0];
                we_ent.seg_start = rq_nstart[ADDR_BITS-1:0];
                we_ent.seg_end   = r_pe.seg_end;
                n_cnt            = r_cnt + CW'(1);
                n_state          = S_RQ_W0;
            end

            S_RQ_W0: begin
                ram_we           = 1'b1;
                ram_wa           = r_pi;
                we_ent.seg_start = r_pe.seg_start;
                we_ent.seg_end   = rq_end[ADDR_BITS-1:0];
                we_ent.used      = 1'b1;
                we_ent.owner     = r_item.proc_id;
                n_res            = '0;
                n_res.status     = ST_OK;
                n_res.seg_start  = r_pe.seg_start;
                n_res.seg_end    = rq_end[ADDR_BITS-1:0];
                n_res.seg_in_use = 1'b1;
                n_res.seg_owner  = r_item.proc_id;
                n_res.last       = 1'b1;
                n_state          = S_EMIT;
            end

            S_RL_RDN: begin
                ram_ra  = pi_nx[IW-1:0];
                n_state = S_RL_GOTN;
            end

            // Merge with free neighbors, then close the gap
            S_RL_GOTN: begin
                ram_we           = 1'b1;
                ram_wa           = pfree ? r_pi - IW'(1) : r_pi;
                we_ent.seg_start = pfree ? r_prev.seg_start : r_pe.seg_start;
                we_ent.seg_end   = nfree ? rd.seg_end : r_pe.seg_end;
                n_res            = '0;
                n_res.status     = ST_OK;
                n_res.seg_start  = we_ent.seg_start;
                n_res.seg_end    = we_ent.seg_end;
                n_res.last       = 1'b1;
                n_src            = rl_p + rl_d;
                n_wa             = rl_p;
                n_left           = (rl_d == '0) ? '0 : r_cnt - rl_p - rl_d;
                n_up             = 1'b0;
                n_sdv            = 1'b0;
                n_cnt            = r_cnt - rl_d;
                n_after          = S_EMIT;
                n_state          = S_SHIFT;
            end

            S_CP_END: begin
                if (r_anyfree) begin
                    ram_we           = 1'b1;
                    ram_wa           = r_nw[IW-1:0];
                    we_ent.seg_start = r_next[ADDR_BITS-1:0];
                    we_ent.seg_end   = tot_m1[ADDR_BITS-1:0];
                    n_cnt            = r_nw + CW'(1);
                    n_res            = '0;
                    n_res.status     = ST_OK;
                    n_res.seg_start  = r_next[ADDR_BITS-1:0];
                    n_res.seg_end    = tot_m1[ADDR_BITS-1:0];
                    n_res.last       = 1'b1;
                end else begin
                    n_res = err_res(ST_NOFREE);
                end
                n_state = S_EMIT;
            end

            // Report: read an entry once the output slot will be free
            S_RP_RD: begin
                if (!r_ov || i_out_ready) begin
                    ram_ra  = r_ri[IW-1:0];
                    n_state = S_RP_LD;
                end
            end

            S_RP_LD: begin
                n_out.status     = ST_OK;
                n_out.seg_start  = rd.seg_start;
                n_out.seg_end    = rd.seg_end;
                n_out.seg_in_use = rd.used;
                n_out.seg_owner  = rd.owner;
                n_out.last       = rep_last;
                n_ov             = 1'b1;
                if (rep_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_ri    = r_ri + CW'(1);
                    n_state = S_RP_RD;
                end
            end

            S_EMIT: begin
                if (!r_ov || i_out_ready) begin
                    n_out   = r_res;
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase

        // Size write: clamp and rebuild the table
        if (i_cfg_we) begin
            if (i_cfg_data == '0) begin
                n_tot = SIZE_W'(1);
            end else if (i_cfg_data > TOT_MAX) begin
                n_tot = TOT_MAX;
            end else begin
                n_tot = i_cfg_data;
            end
            n_state = S_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_after   <= S_IDLE;
            r_tot     <= TOT_MAX;
            r_cnt     <= CW'(1);
            r_dv      <= 1'b0;
            r_stop    <= 1'b0;
            r_found   <= 1'b0;
            r_sdv     <= 1'b0;
            r_up      <= 1'b0;
            r_anyfree <= 1'b0;
            r_ov      <= 1'b0;
            r_ri      <= '0;
            r_src     <= '0;
            r_wa      <= '0;
            r_left    <= '0;
            r_nw      <= '0;
        end else begin
            r_state   <= n_state;
            r_after   <= n_after;
            r_tot     <= n_tot;
            r_cnt     <= n_cnt;
            r_dv      <= n_dv;
            r_stop    <= n_stop;
            r_found   <= n_found;
            r_sdv     <= n_sdv;
            r_up      <= n_up;
            r_anyfree <= n_anyfree;
            r_ov      <= n_ov;
            r_ri      <= n_ri;
            r_src     <= n_src;
            r_wa      <= n_wa;
            r_left    <= n_left;
            r_nw      <= n_nw;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_di   <= n_di;
        r_pi   <= n_pi;
        r_pe   <= n_pe;
        r_prev <= n_prev;
        r_psz  <= n_psz;
        r_next <= n_next;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out       = r_out;

endmodule
`default_nettype wire

// ===== hw/rtl/csa_chk.sv =====
`default_nettype none
`include "assert_macros.svh"
module csa_chk import csa_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_out_valid,
    input wire logic              i_out_ready,
    input wire t_res_item         o_out
);

    // A stalled result holds
    `CSA_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out), "result dropped or changed while stalled")

    // Errors carry no segment and close the item
    `CSA_ASSERT_IMP(a_err_shape, o_out_valid && o_out.status != ST_OK, o_out.last && o_out.seg_start == '0 && o_out.seg_end == '0 && !o_out.seg_in_use && o_out.seg_owner == '0, "malformed error result")

    // Free segments have no owner
    `CSA_ASSERT_IMP(a_free_owner, o_out_valid && !o_out.seg_in_use, o_out.seg_owner == '0, "free segment shows an owner")

    // Segment ranges are never reversed
    `CSA_ASSERT_IMP(a_range, o_out_valid, o_out.seg_start <= o_out.seg_end, "segment end below start")

endmodule

bind contiguous_segment_allocator csa_chk u_csa_chk (.*);
`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none

module testbench;
    import csa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSEG = 32;

    // Segment table model and expected-result queue
    class seg_scoreboard;
        int unsigned  tot;
        int unsigned  s_start[NSEG];
        int unsigned  s_end[NSEG];
        bit           s_used[NSEG];
        int unsigned  s_owner[NSEG];
        int unsigned  count;
        t_res_item    pending[$];
        int           errors;
        int           n_results;

        function void rebuild(int unsigned size);
            for (int i = 0; i < NSEG; i++) begin
                s_start[i] = 0; s_end[i] = 0; s_used[i] = 0; s_owner[i] = 0;
            end
            s_end[0] = size - 1;
            count = 1;
        endfunction

        function void set_total(logic [SIZE_W-1:0] v);
            int unsigned t;
            t = v;
            if (t == 0) t = 1;
            if (t > 65536) t = 65536;
            tot = t;
            rebuild(t);
        endfunction

        function int unsigned span(int i);
            return s_end[i] - s_start[i] + 1;
        endfunction

        function void push(logic [2:0] st, int unsigned a, int unsigned b, bit u,
                           int unsigned o, bit l);
            t_res_item r;
            r.status = st;
            r.seg_start = a[15:0];
            r.seg_end = b[15:0];
            r.seg_in_use = u;
            r.seg_owner = o[7:0];
            r.last = l;
            pending.push_back(r);
        endfunction

        function void drop(int i);
            for (int k = i; k + 1 < count; k++) begin
                s_start[k] = s_start[k+1]; s_end[k] = s_end[k+1];
                s_used[k] = s_used[k+1]; s_owner[k] = s_owner[k+1];
            end
            count--;
        endfunction

        // Note an accepted command item and predict its results
        function void note_cmd(t_cmd_item it);
            int pick;
            int unsigned sz, freed, nxt, n, j;
            pick = -1;
            sz = it.req_size;
            case (it.cmd)
                CMD_REQ: begin
                    if (it.strategy == STRAT_BAD) begin
                        push(ST_BADSTRAT, 0, 0, 0, 0, 1);
                        return;
                    end
                    if (sz == 0) begin
                        push(ST_NOFIT, 0, 0, 0, 0, 1);
                        return;
                    end
                    for (int i = 0; i < count; i++) begin
                        if (s_used[i] || span(i) < sz) continue;
                        if (pick < 0) begin
                            pick = i;
                            if (it.strategy == STRAT_FIRST) break;
                            continue;
                        end
                        if (it.strategy == STRAT_BEST && span(i) < span(pick)) pick = i;
                        if (it.strategy == STRAT_WORST && span(i) > span(pick)) pick = i;
                    end
                    if (pick < 0) begin
                        push(ST_NOFIT, 0, 0, 0, 0, 1);
                        return;
                    end
                    if (span(pick) != sz) begin
                        if (count >= NSEG) begin
                            push(ST_FULL, 0, 0, 0, 0, 1);
                            return;
                        end
                        for (int k = count; k > pick; k--) begin
                            s_start[k] = s_start[k-1]; s_end[k] = s_end[k-1];
                            s_used[k] = s_used[k-1]; s_owner[k] = s_owner[k-1];
                        end
                        count++;
                        s_end[pick] = s_start[pick] + sz - 1;
                        s_start[pick+1] = s_end[pick] + 1;
                    end
                    s_used[pick] = 1;
                    s_owner[pick] = it.proc_id;
                    push(ST_OK, s_start[pick], s_end[pick], 1, it.proc_id, 1);
                end
                CMD_REL: begin
                    for (int i = 0; i < count; i++)
                        if (s_used[i] && s_owner[i] == it.proc_id) begin
                            pick = i;
                            break;
                        end
                    if (pick < 0) begin
                        push(ST_UNKNOWN, 0, 0, 0, 0, 1);
                        return;
                    end
                    s_used[pick] = 0;
                    s_owner[pick] = 0;
                    if (pick + 1 < count && !s_used[pick+1]) begin
                        s_end[pick] = s_end[pick+1];
                        drop(pick + 1);
                    end
                    if (pick > 0 && !s_used[pick-1]) begin
                        s_end[pick-1] = s_end[pick];
                        drop(pick);
                        pick--;
                    end
                    push(ST_OK, s_start[pick], s_end[pick], 0, 0, 1);
                end
                CMD_CMP: begin
                    freed = 0;
                    nxt = 0;
                    n = 0;
                    for (int i = 0; i < count; i++)
                        if (!s_used[i]) freed += span(i);
                    if (freed == 0) begin
                        push(ST_NOFREE, 0, 0, 0, 0, 1);
                        return;
                    end
                    for (int i = 0; i < count; i++) begin
                        if (!s_used[i]) continue;
                        j = span(i);
                        s_start[n] = nxt;
                        s_end[n] = nxt + j - 1;
                        s_used[n] = 1;
                        s_owner[n] = s_owner[i];
                        nxt += j;
                        n++;
                    end
                    s_start[n] = nxt; s_end[n] = tot - 1; s_used[n] = 0; s_owner[n] = 0;
                    count = n + 1;
                    for (int i = count; i < NSEG; i++) begin
                        s_start[i] = 0; s_end[i] = 0; s_used[i] = 0; s_owner[i] = 0;
                    end
                    push(ST_OK, s_start[n], s_end[n], 0, 0, 1);
                end
                default: begin
                    for (int i = 0; i < count; i++)
                        push(ST_OK, s_start[i], s_end[i], s_used[i], s_owner[i],
                             i + 1 == count);
                end
            endcase
        endfunction

        // Compare one result item with the oldest expectation
        function void check_res(t_res_item got);
            t_res_item e;
            n_results++;
            if (pending.size() == 0) begin
                $error("unexpected result item %p", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status) begin
                $error("status: expected %0d actual %0d", e.status, got.status); errors++;
            end
            if (got.seg_start !== e.seg_start) begin
                $error("seg_start: expected %0d actual %0d", e.seg_start, got.seg_start);
                errors++;
            end
            if (got.seg_end !== e.seg_end) begin
                $error("seg_end: expected %0d actual %0d", e.seg_end, got.seg_end); errors++;
            end
            if (got.seg_in_use !== e.seg_in_use) begin
                $error("seg_in_use: expected %0d actual %0d", e.seg_in_use, got.seg_in_use);
                errors++;
            end
            if (got.seg_owner !== e.seg_owner) begin
                $error("seg_owner: expected %0d actual %0d", e.seg_owner, got.seg_owner);
                errors++;
            end
            if (got.last !== e.last) begin
                $error("last: expected %0d actual %0d", e.last, got.last); errors++;
            end
        endfunction
    endclass

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              i_in_valid = 0;
    logic              o_in_ready;
    t_cmd_item         i_in = '0;
    logic              o_out_valid;
    logic              i_out_ready = 0;
    t_res_item         o_out;
    logic              i_cfg_we = 0;
    logic [SIZE_W-1:0] i_cfg_data = '0;

    seg_scoreboard sb;
    bit            hold_off = 0;
    int            n_items = 0;
    int            n_cfg = 0;

    contiguous_segment_allocator u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Watchdog
    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

    // Result side: sample at the rising edge, stall on its own pattern
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_res(o_out);
    end

    initial begin
        int mode;
        mode = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off) i_out_ready <= 1'b0;
            else begin
                if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 3) != 0);
                    2: i_out_ready <= 1'($urandom_range(0, 1));
                    default: i_out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Offer one command item and wait until it is taken
    task automatic send_cmd(logic [1:0] c, logic [7:0] id, logic [16:0] sz,
                            logic [1:0] st);
        t_cmd_item it;
        it.cmd = c; it.proc_id = id; it.req_size = sz; it.strategy = st;
        i_in <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_cmd(it);
        n_items++;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Sender gap between bursts
    task automatic gap();
        int g;
        g = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        repeat (g) @(negedge i_clk);
    endtask

    // Write total_size once the block has drained
    task automatic write_total(logic [SIZE_W-1:0] v);
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        i_cfg_data <= v;
        i_cfg_we <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_total(v);
        n_cfg++;
    endtask

    function automatic logic [16:0] rand_size();
        int unsigned t;
        t = sb.tot;
        case ($urandom_range(0, 7))
            0: return 17'($urandom_range(0, 131071));
            1: return 17'(t);
            2: return 17'($urandom_range(1, 4));
            default: return 17'($urandom_range(1, (t / 8 > 1) ? t / 8 : 1));
        endcase
    endfunction

    initial begin
        logic [16:0] sizes[5];
        sb = new();
        sb.set_total(65536);
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed: strategies, error codes, merges, compaction
        send_cmd(CMD_REP, 8'd0, 17'd0, STRAT_FIRST);
        send_cmd(CMD_CMP, 8'd0, 17'd0, STRAT_FIRST);
        send_cmd(CMD_REQ, 8'd1, 17'd100, STRAT_BAD);
        send_cmd(CMD_REQ, 8'd1, 17'd0, STRAT_FIRST);
        send_cmd(CMD_REQ, 8'd1, 17'h1ffff, STRAT_FIRST);
        send_cmd(CMD_REQ, 8'd0, 17'd10, STRAT_FIRST);
        send_cmd(CMD_REQ, 8'd255, 17'd20, STRAT_BEST);
        send_cmd(CMD_REQ, 8'd255, 17'd30, STRAT_WORST);
        send_cmd(CMD_REL, 8'd7, 17'd0, STRAT_FIRST);
        send_cmd(CMD_REL, 8'd0, 17'd0, STRAT_FIRST);
        send_cmd(CMD_REQ, 8'd5, 17'd5, STRAT_BEST);
        send_cmd(CMD_REL, 8'd255, 17'd0, STRAT_FIRST);
        send_cmd(CMD_REP, 8'd0, 17'd0, STRAT_FIRST);
        send_cmd(CMD_CMP, 8'd0, 17'd0, STRAT_FIRST);
        send_cmd(CMD_REQ, 8'haa, 17'd65536 - 17'd35, STRAT_FIRST);
        send_cmd(CMD_CMP, 8'd0, 17'd0, STRAT_FIRST);
        send_cmd(CMD_REP, 8'd0, 17'd0, STRAT_FIRST);

        // Small memory: fill the table with unit segments
        write_total(17'd0);
        send_cmd(CMD_REQ, 8'd1, 17'd1, STRAT_FIRST);
        send_cmd(CMD_REQ, 8'd1, 17'd1, STRAT_FIRST);
        write_total(17'd40);
        for (int i = 0; i < 33; i++) send_cmd(CMD_REQ, 8'(i + 1), 17'd1, STRAT_FIRST);
        send_cmd(CMD_REP, 8'd0, 17'd0, STRAT_FIRST);
        write_total(17'h1ffff);

        // Long receiver hold-off while the sender keeps going
        fork
            begin
                hold_off = 1;
                repeat (600) @(negedge i_clk);
                hold_off = 0;
            end
            for (int i = 0; i < 12; i++)
                send_cmd(CMD_REQ, 8'($urandom_range(1, 255)), 17'd50, STRAT_FIRST);
        join

        // Random phases across several memory sizes
        sizes = '{17'd65536, 17'd1000, 17'd64, 17'd1, 17'h10001};
        for (int ph = 0; ph < 5; ph++) begin
            write_total(sizes[ph]);
            for (int i = 0; i < 48; i++) begin
                int r;
                logic [7:0] id;
                r = $urandom_range(0, 99);
                id = (r % 9 == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, 12));
                if (r < 50) send_cmd(CMD_REQ, id, rand_size(), 2'($urandom_range(0, 3)));
                else if (r < 80) send_cmd(CMD_REL, id, 17'($urandom), STRAT_FIRST);
                else if (r < 90) send_cmd(CMD_CMP, id, 17'($urandom), 2'($urandom));
                else send_cmd(CMD_REP, id, 17'($urandom), 2'($urandom));
                gap();
            end
        end

        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        $display("covered %0d command items, %0d result items, %0d total_size writes",
                 n_items, sb.n_results, n_cfg);
        $display("fit strategies, merges, compaction, full table and error codes exercised");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/csa_pkg.sv
hw/rtl/csa_ram.sv
hw/rtl/contiguous_segment_allocator.sv
hw/rtl/csa_chk.sv
sim/testbench.sv
